// File: src/clsr_pkg.sv
package clsr_pkg;

  // Shuffle table geometry.
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 8);

  // Generator constants.
  localparam logic [30:0] IM1         = 31'd2147483563;
  localparam logic [30:0] IM2         = 31'd2147483399;
  localparam logic [30:0] IMM1        = 31'd2147483562;
  localparam logic [30:0] IA1         = 31'd40014;
  localparam logic [30:0] IA2         = 31'd40692;
  localparam logic [30:0] SECOND_SEED = 31'd123456789;

  // 2^31 is congruent to these values modulo IM1 and IM2.
  localparam logic [7:0] FOLD1 = 8'd85;
  localparam logic [7:0] FOLD2 = 8'd249;

  // Table slot width and the coin threshold.
  localparam logic [30:0] NDIV     = 31'(64'd1 + 64'(IMM1) / TABLE_DEPTH);
  localparam logic [30:0] HALF_IM1 = 31'(64'(IMM1) / 2);

  // Operation codes of the input beat.
  localparam logic MODE_RESEED = 1'b0;
  localparam logic MODE_DRAW   = 1'b1;

  typedef enum logic {
    MOD_1,
    MOD_2
  } mod_sel_t;

  typedef enum logic {
    MM_IDLE,
    MM_FOLD
  } mm_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED_ISSUE,
    S_SEED_WAIT,
    S_G1_ISSUE,
    S_G1_WAIT,
    S_G2_ISSUE,
    S_G2_WAIT,
    S_COMB,
    S_SCALE_ISSUE,
    S_SCALE_WAIT,
    S_OUT
  } seq_state_t;

  typedef struct packed {
    logic        start;
    mod_sel_t    sel;
    logic [30:0] opa;
    logic [30:0] opb;
  } mm_req_t;

  typedef struct packed {
    logic        done;
    logic [30:0] rem;
    logic [31:0] quo;
  } mm_rsp_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [30:0]      data;
  } tbl_wr_t;

  typedef struct packed {
    logic        mode;
    logic [30:0] range;
  } clsr_in_t;

  typedef struct packed {
    logic [30:0] value;
    logic [30:0] scaled;
    logic        coin;
  } clsr_out_t;

endpackage

// File: src/clsr_modmul.sv
module clsr_modmul (
  input  logic             clk,
  input  logic             rst_n,
  input  clsr_pkg::mm_req_t req,
  output clsr_pkg::mm_rsp_t rsp
);
  import clsr_pkg::*;

  mm_state_t   st_r, st_nxt;
  mod_sel_t    sel_r, sel_nxt;
  logic [61:0] r_r, r_nxt;
  logic [31:0] q_r, q_nxt;

  logic [61:0] mul_p;
  logic [30:0] hi, lo;
  logic [7:0]  fold_k;
  logic [30:0] modulus;
  logic [38:0] fold_p;
  logic [61:0] folded;
  logic        fold_done;
  logic        ge;

  // Operand product, registered before any folding.
  assign mul_p = 62'(req.opa) * 62'(req.opb);

  // One fold step: hi * 2^31 + lo is replaced by hi * k + lo, and hi adds to the quotient.
  assign hi        = r_r[61:31];
  assign lo        = r_r[30:0];
  assign fold_k    = (sel_r == MOD_1) ? FOLD1 : FOLD2;
  assign modulus   = (sel_r == MOD_1) ? IM1 : IM2;
  assign fold_p    = 39'(hi) * 39'(fold_k);
  assign folded    = 62'(fold_p) + 62'(lo);
  assign fold_done = (hi == '0);
  assign ge        = (lo >= modulus);

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      MM_IDLE: begin
        if (req.start) st_nxt = MM_FOLD;
      end
      MM_FOLD: begin
        if (fold_done) st_nxt = MM_IDLE;
      end
      default: st_nxt = MM_IDLE;
    endcase
  end

  // Datapath and result.
  always_comb begin
    r_nxt    = r_r;
    q_nxt    = q_r;
    sel_nxt  = sel_r;
    rsp.done = 1'b0;
    rsp.rem  = ge ? (lo - modulus) : lo;
    rsp.quo  = q_r + 32'(ge);
    case (st_r)
      MM_IDLE: begin
        if (req.start) begin
          r_nxt   = mul_p;
          q_nxt   = '0;
          sel_nxt = req.sel;
        end
      end
      MM_FOLD: begin
        if (fold_done) begin
          rsp.done = 1'b1;
        end else begin
          r_nxt = folded;
          q_nxt = q_r + 32'(hi);
        end
      end
      default: begin
        rsp.done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= MM_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r   <= r_nxt;
    q_r   <= q_nxt;
    sel_r <= sel_nxt;
  end

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> (st_r == MM_IDLE))
    else $error("modmul started while busy");

  a_fold_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == MM_FOLD && !fold_done) |=> (r_r < $past(r_r)))
    else $error("fold step did not reduce the residue");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (rsp.rem < modulus))
    else $error("modmul remainder not reduced");
`endif

endmodule

// File: src/clsr_table.sv
module clsr_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  clsr_pkg::tbl_wr_t             wr,
  input  logic [clsr_pkg::IDX_W-1:0]    rd_addr,
  output logic [30:0]                   rd_data
);
  import clsr_pkg::*;

  logic [30:0]            mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [30:0]            rd_r;
  logic                   rd_vld_r;

  // An entry never written reads as zero.
  assign rd_data = rd_vld_r ? rd_r : '0;

  // Storage write and registered read.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_r <= mem[rd_addr];
  end

  // Per-entry valid bits, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      rd_vld_r <= valid_r[rd_addr];
    end
  end

endmodule

// File: src/combined_lcg_shuffle_rng.sv
// Draw: steps both generators, combines the result with the table entry and scales it; the
// generator steps and the scaling each pass through the shared multiply-fold unit, one fold step at a time.
// Reseed: forty generator steps through the same unit.
// Throughput: one item at a time; the next beat can be taken in the cycle after the result is
// loaded, while that result may still wait in the output register. Reset (synchronous,
// rst_n low) sets the seed to 1, both generators and the last output to 0, and empties the table.
module combined_lcg_shuffle_rng (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [30:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  clsr_pkg::clsr_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output clsr_pkg::clsr_out_t  out_data
);
  import clsr_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic [30:0]       seed_r;
  logic [30:0]       g1_r, g1_nxt;
  logic [30:0]       g2_r, g2_nxt;
  logic [30:0]       last_r, last_nxt;
  logic [30:0]       v_r, v_nxt;
  logic [30:0]       scaled_r, scaled_nxt;
  logic [30:0]       range_r, range_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  clsr_out_t         out_data_r, out_data_nxt;

  mm_req_t           mm_req;
  mm_rsp_t           mm_rsp;
  tbl_wr_t           tbl_wr;
  logic [30:0]       tbl_rd;

  logic [30:0]       seed_red;
  logic [30:0]       seed_fix;
  logic [31:0]       diff;
  logic [31:0]       comb_v;
  logic              out_free;
  logic              out_load;

  clsr_modmul u_modmul (
    .clk (clk),
    .rst_n (rst_n),
    .req (mm_req),
    .rsp (mm_rsp)
  );

  clsr_table u_table (
    .clk (clk),
    .rst_n (rst_n),
    .wr (tbl_wr),
    .rd_addr (idx_r),
    .rd_data (tbl_rd)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Seed reduced into 1..IM1-1.
  assign seed_red = (seed_r >= IM1) ? (seed_r - IM1) : seed_r;
  assign seed_fix = (seed_red == '0) ? 31'd1 : seed_red;

  // Table output minus second generator, wrapped into 1..IM1-1.
  assign diff   = {1'b0, tbl_rd} - {1'b0, g2_r};
  assign comb_v = (tbl_rd <= g2_r) ? (diff + {1'b0, IMM1}) : diff;

  // Slot index: the number of slot boundaries at or below the last output.
  always_comb begin
    idx_nxt = '0;
    for (int k = 1; k < TABLE_DEPTH; k++) begin
      if (64'(last_r) >= 64'(k) * 64'(NDIV)) idx_nxt = IDX_W'(k);
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.mode == MODE_RESEED) ? S_SEED_ISSUE : S_G1_ISSUE;
        end
      end
      S_SEED_ISSUE: state_nxt = S_SEED_WAIT;
      S_SEED_WAIT: begin
        if (mm_rsp.done) state_nxt = (j_r == '0) ? S_OUT : S_SEED_ISSUE;
      end
      S_G1_ISSUE: state_nxt = S_G1_WAIT;
      S_G1_WAIT: begin
        if (mm_rsp.done) state_nxt = S_G2_ISSUE;
      end
      S_G2_ISSUE: state_nxt = S_G2_WAIT;
      S_G2_WAIT: begin
        if (mm_rsp.done) state_nxt = S_COMB;
      end
      S_COMB: state_nxt = S_SCALE_ISSUE;
      S_SCALE_ISSUE: state_nxt = S_SCALE_WAIT;
      S_SCALE_WAIT: begin
        if (mm_rsp.done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs and datapath updates.
  always_comb begin
    g1_nxt      = g1_r;
    g2_nxt      = g2_r;
    last_nxt    = last_r;
    v_nxt       = v_r;
    scaled_nxt  = scaled_r;
    range_nxt   = range_r;
    j_nxt       = j_r;
    out_load    = 1'b0;
    mm_req      = '{start: 1'b0, sel: MOD_1, opa: g1_r, opb: IA1};
    tbl_wr      = '{en: 1'b0, addr: idx_r, data: g1_r};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          range_nxt = in_data.range;
          if (in_data.mode == MODE_RESEED) begin
            g1_nxt = seed_fix;
            g2_nxt = SECOND_SEED;
            j_nxt  = CNT_W'(TABLE_DEPTH + 7);
          end
        end
      end
      S_SEED_ISSUE, S_G1_ISSUE: begin
        mm_req.start = 1'b1;
      end
      S_SEED_WAIT: begin
        if (mm_rsp.done) begin
          g1_nxt      = mm_rsp.rem;
          tbl_wr.en   = (j_r < CNT_W'(TABLE_DEPTH));
          tbl_wr.addr = j_r[IDX_W-1:0];
          tbl_wr.data = mm_rsp.rem;
          if (j_r == '0) begin
            last_nxt   = mm_rsp.rem;
            v_nxt      = '0;
            scaled_nxt = '0;
          end else begin
            j_nxt = j_r - CNT_W'(1);
          end
        end
      end
      S_G1_WAIT: begin
        if (mm_rsp.done) g1_nxt = mm_rsp.rem;
      end
      S_G2_ISSUE: begin
        mm_req = '{start: 1'b1, sel: MOD_2, opa: g2_r, opb: IA2};
      end
      S_G2_WAIT: begin
        if (mm_rsp.done) g2_nxt = mm_rsp.rem;
      end
      S_COMB: begin
        tbl_wr.en = 1'b1;
        last_nxt  = comb_v[30:0];
        v_nxt     = comb_v[30:0];
      end
      S_SCALE_ISSUE: begin
        mm_req = '{start: 1'b1, sel: MOD_1, opa: v_r, opb: range_r};
      end
      S_SCALE_WAIT: begin
        if (mm_rsp.done) scaled_nxt = mm_rsp.quo[30:0];
      end
      S_OUT: begin
        out_load = out_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Output register: holds a beat until it is taken.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt       = 1'b1;
      out_data_nxt.value  = v_r;
      out_data_nxt.scaled = scaled_r;
      out_data_nxt.coin   = (v_r > HALF_IM1);
    end
  end

  // Control and generator state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seed_r      <= 31'd1;
      g1_r        <= '0;
      g2_r        <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) seed_r <= cfg_wdata;
      g1_r        <= g1_nxt;
      g2_r        <= g2_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    scaled_r   <= scaled_nxt;
    range_r    <= range_nxt;
    j_r        <= j_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef NO_ASSERTIONS
  a_tbl_wr_phase: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_wr.en |-> (state_r == S_SEED_WAIT || state_r == S_COMB))
    else $error("table written outside reseed or combine");

  a_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    mm_rsp.done |-> (state_r == S_SEED_WAIT || state_r == S_G1_WAIT ||
                     state_r == S_G2_WAIT || state_r == S_SCALE_WAIT))
    else $error("modmul finished while sequencer not waiting");

  a_last_range: assert property (@(posedge clk) disable iff (!rst_n)
    last_r < IM1)
    else $error("last output out of range");

  a_draw_value: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMB) |=> (v_r != '0 && v_r < IM1))
    else $error("drawn value outside 1..IM1-1");
`endif

endmodule

// File: dv/tb.sv
module tb;
  import clsr_pkg::*;

  // Predicts every result of the generator and checks the beats that leave it.
  class lcg_shuffle_model;
    logic [30:0] seed_reg;
    logic [30:0] gen_a;
    logic [30:0] gen_b;
    logic [30:0] prev_value;
    logic [30:0] slots [TABLE_DEPTH];
    clsr_out_t   pending_draws [$];
    int          mismatches;

    function new();
      seed_reg   = 31'd1;
      gen_a      = '0;
      gen_b      = '0;
      prev_value = '0;
      foreach (slots[i]) slots[i] = '0;
      mismatches = 0;
    endfunction

    // One exact multiplicative congruential step.
    function logic [30:0] mcg(logic [30:0] z, logic [30:0] mult, logic [30:0] modulus);
      logic [63:0] prod;
      prod = 64'(z) * 64'(mult);
      return 31'(prod % 64'(modulus));
    endfunction

    function void load_seed(logic [30:0] v);
      seed_reg = v;
    endfunction

    function int outstanding();
      return pending_draws.size();
    endfunction

    // Advances the state by one accepted input beat and queues the result it causes.
    function void take_beat(clsr_in_t beat);
      logic [30:0]      start;
      logic [IDX_W:0]   slot;
      longint           comb;
      logic [30:0]      v;
      clsr_out_t        res;
      res = '0;
      if (beat.mode == MODE_RESEED) begin
        start = seed_reg;
        if (start >= IM1) start = start - IM1;
        if (start == 0) start = 31'd1;
        gen_b = SECOND_SEED;
        gen_a = start;
        // Eight warm-up steps, then the table fills from the top slot down.
        for (int j = TABLE_DEPTH + 7; j >= 0; j--) begin
          gen_a = mcg(gen_a, IA1, IM1);
          if (j < TABLE_DEPTH) slots[j] = gen_a;
        end
        prev_value = slots[0];
      end else begin
        gen_a = mcg(gen_a, IA1, IM1);
        gen_b = mcg(gen_b, IA2, IM2);
        slot = (IDX_W + 1)'(prev_value / NDIV);
        if (slot >= TABLE_DEPTH) slot = (IDX_W + 1)'(TABLE_DEPTH - 1);
        comb = longint'(slots[slot[IDX_W-1:0]]) - longint'(gen_b);
        slots[slot[IDX_W-1:0]] = gen_a;
        if (comb < 1) comb = comb + longint'(IMM1);
        v = comb[30:0];
        prev_value = v;
        res.value  = v;
        res.scaled = 31'((64'(v) * 64'(beat.range)) / 64'(IM1));
        res.coin   = (64'(v) * 64'd2) > 64'(IM1);
      end
      pending_draws.push_back(res);
    endfunction

    // Compares one result beat with the oldest expectation, field by field.
    function void check_draw(clsr_out_t got);
      clsr_out_t want;
      if (pending_draws.size() == 0) begin
        $display("%0t: unexpected result value %h scaled %h coin %b", $time,
                 got.value, got.scaled, got.coin);
        mismatches++;
        return;
      end
      want = pending_draws.pop_front();
      if (got.value !== want.value) begin
        $display("%0t: value expected %h got %h", $time, want.value, got.value);
        mismatches++;
      end
      if (got.scaled !== want.scaled) begin
        $display("%0t: scaled expected %h got %h", $time, want.scaled, got.scaled);
        mismatches++;
      end
      if (got.coin !== want.coin) begin
        $display("%0t: coin expected %b got %b", $time, want.coin, got.coin);
        mismatches++;
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 3000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  logic [30:0] cfg_wdata;
  logic      in_valid;
  logic      in_stall;
  clsr_in_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  clsr_out_t out_data;

  lcg_shuffle_model model;
  int burst_left = 0;
  int idle_cycles = 0;
  int seg_left = 0;
  int run_left = 0;
  int stall_kind = 0;
  int stall_tick = 0;

  combined_lcg_shuffle_rng dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sample both channels and the seed port at the rising edge; watch for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) model.load_seed(cfg_wdata);
      if (in_valid && !in_stall) model.take_beat(in_data);
      if (out_valid && !out_stall) model.check_draw(out_data);
      if (cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL combined_lcg_shuffle_rng");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver back-pressure: segments of no stall, coin flips, long runs and a fixed beat.
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (seg_left == 0) begin
      seg_left   <= $urandom_range(50, 400);
      stall_kind <= $urandom_range(0, 3);
    end else begin
      seg_left <= seg_left - 1;
    end
    case (stall_kind)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      2: begin
        if (run_left == 0) begin
          out_stall <= ~out_stall;
          run_left  <= $urandom_range(1, 40);
        end else begin
          run_left <= run_left - 1;
        end
      end
      default: out_stall <= (stall_tick % 3) != 0;
    endcase
  end

  // Offers one beat; the sender idles between bursts of random length.
  task automatic issue(logic m, logic [30:0] r);
    int gap;
    if (burst_left == 0) begin
      in_valid = 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_data.mode  = m;
    in_data.range = r;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
  endtask

  // Holds the sender back until every queued result has come out.
  task automatic drain_results();
    in_valid = 1'b0;
    burst_left = 0;
    while (model.outstanding() != 0) @(negedge clk);
  endtask

  task automatic write_seed(logic [30:0] v);
    drain_results();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [30:0] pick_range();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom_range(1, 16));
      default: return 31'($urandom);
    endcase
  endfunction

  initial begin
    logic [30:0] phase_seed;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    model = new();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Draws on the all-zero state before any reseed, then the default seed.
    issue(MODE_DRAW, 31'h7FFF_FFFF);
    issue(MODE_DRAW, '0);
    issue(MODE_DRAW, 31'd1);
    issue(MODE_DRAW, pick_range());
    issue(MODE_RESEED, 31'h7FFF_FFFF);
    issue(MODE_DRAW, 31'h7FFF_FFFF);
    issue(MODE_DRAW, '0);
    // A zero seed, a seed equal to the modulus and the largest seeds.
    write_seed('0);
    issue(MODE_RESEED, '0);
    issue(MODE_DRAW, 31'h7FFF_FFFF);
    write_seed(IM1);
    issue(MODE_RESEED, 31'd1);
    issue(MODE_DRAW, 31'd1);
    write_seed(31'h7FFF_FFFF);
    issue(MODE_RESEED, pick_range());
    issue(MODE_DRAW, pick_range());
    issue(MODE_DRAW, pick_range());
    write_seed(IMM1);
    issue(MODE_RESEED, '0);
    issue(MODE_RESEED, '0);
    issue(MODE_DRAW, 31'h7FFF_FFFF);
    issue(MODE_DRAW, '0);

    // Random phases: mostly a reseed followed by a long run of draws.
    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 0) phase_seed = 31'd1;
      else if (phase == 1) phase_seed = IM1 + 31'd1;
      else phase_seed = 31'($urandom);
      write_seed(phase_seed);
      for (int k = 0; k < 200; k++) begin
        if ((k == 0 && $urandom_range(0, 4) != 0) || $urandom_range(0, 29) == 0)
          issue(MODE_RESEED, 31'($urandom));
        else
          issue(MODE_DRAW, pick_range());
        if (k == 100 || $urandom_range(0, 249) == 0) drain_results();
      end
    end

    drain_results();
    repeat (50) @(negedge clk);
    if (model.mismatches == 0 && model.outstanding() == 0) begin
      $display("PASS combined_lcg_shuffle_rng");
    end else begin
      $display("FAIL combined_lcg_shuffle_rng");
    end
    $finish;
  end
endmodule
